// ----- src/y4m_stream_header_parser_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Y4M stream header parser
// ----------------------------------------------------------------------------
`ifndef Y4M_STREAM_HEADER_PARSER_TOP_MACROS_SVH
`define Y4M_STREAM_HEADER_PARSER_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define Y4M_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset
`define Y4M_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/y4m_pkg.sv -----
// ----------------------------------------------------------------------------
// y4m_pkg
// Types, constants and header tables shared by the Y4M stream header parser.
// ----------------------------------------------------------------------------
package y4m_pkg;

    // Number widths
    localparam int DIM_BITS   = 16;
    localparam int RATIO_BITS = 32;
    localparam int ACC_BITS   = (DIM_BITS > RATIO_BITS) ? DIM_BITS : RATIO_BITS;
    localparam int AREA_BITS  = 2 * DIM_BITS;
    localparam int PAY_BITS   = AREA_BITS + 2;
    localparam int POS_BITS   = 6;

    localparam logic [ACC_BITS-1:0] DIM_MAX   = ACC_BITS'({DIM_BITS{1'b1}});
    localparam logic [ACC_BITS-1:0] RATIO_MAX = ACC_BITS'({RATIO_BITS{1'b1}});

    // Event codes
    localparam logic [2:0] EV_CONSUMED = 3'd0;
    localparam logic [2:0] EV_STREAM   = 3'd1;
    localparam logic [2:0] EV_FRAME    = 3'd2;
    localparam logic [2:0] EV_PAYLOAD  = 3'd3;
    localparam logic [2:0] EV_ERROR    = 3'd4;

    // Pixel formats
    localparam logic FMT_YUV420 = 1'b0;
    localparam logic FMT_BGRA   = 1'b1;

    // Header positions
    localparam logic [POS_BITS-1:0] POS_START       = 6'd0;
    localparam logic [POS_BITS-1:0] POS_AFTER_MAGIC = 6'd9;
    localparam logic [POS_BITS-1:0] POS_HEADER_END  = 6'd31;
    localparam logic [POS_BITS-1:0] POS_FRAME       = 6'd32;
    localparam logic [POS_BITS-1:0] POS_FRAME_END   = 6'd37;
    localparam logic [POS_BITS-1:0] POS_PAYLOAD     = 6'd38;
    localparam logic [POS_BITS-1:0] POS_ERROR       = 6'd39;

    localparam logic [POS_BITS-1:0] MAGIC_LEN_YUV  = 6'd9;
    localparam logic [POS_BITS-1:0] MAGIC_LEN_BGRA = 6'd8;

    localparam logic [7:0] CHR_NONE    = 8'h00;
    localparam logic [7:0] CHR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHR_ZERO    = "0";
    localparam logic [7:0] CHR_NINE    = "9";

    // What a header position expects
    typedef enum logic [2:0] {
        K_MAGIC,
        K_LIT,
        K_FIRST,
        K_MORE,
        K_CHAR,
        K_FRAME,
        K_PAYLOAD,
        K_ERROR
    } pos_kind_t;

    // Which number a digit position feeds
    typedef enum logic [2:0] {
        SLOT_WIDTH,
        SLOT_HEIGHT,
        SLOT_RATE_NUM,
        SLOT_RATE_DEN,
        SLOT_ASPECT_NUM,
        SLOT_ASPECT_DEN
    } num_slot_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic        pixel_format;
        logic [31:0] rate_numerator;
        logic [31:0] rate_denominator;
        logic [7:0]  interlace_code;
        logic [31:0] aspect_numerator;
        logic [31:0] aspect_denominator;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
    } out_item_t;

    function automatic pos_kind_t pos_kind(input logic [POS_BITS-1:0] p);
        pos_kind_t k;
        case (p)
            6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8: k = K_MAGIC;
            6'd9, 6'd10, 6'd13, 6'd14, 6'd17, 6'd18,
            6'd23, 6'd24, 6'd26, 6'd27:                          k = K_LIT;
            6'd11, 6'd15, 6'd19, 6'd21, 6'd28, 6'd30:            k = K_FIRST;
            6'd12, 6'd16, 6'd20, 6'd22, 6'd29, 6'd31:            k = K_MORE;
            6'd25:                                               k = K_CHAR;
            6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37:            k = K_FRAME;
            6'd38:                                               k = K_PAYLOAD;
            default:                                             k = K_ERROR;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] pos_char(input logic [POS_BITS-1:0] p);
        logic [7:0] c;
        case (p)
            6'd9, 6'd13, 6'd17, 6'd23, 6'd26: c = " ";
            6'd10:                            c = "W";
            6'd14:                            c = "H";
            6'd18:                            c = "F";
            6'd20, 6'd29:                     c = ":";
            6'd24:                            c = "I";
            6'd27:                            c = "A";
            6'd31, 6'd37:                     c = CHR_NEWLINE;
            6'd32:                            c = "F";
            6'd33:                            c = "R";
            6'd34:                            c = "A";
            6'd35:                            c = "M";
            6'd36:                            c = "E";
            default:                          c = CHR_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] magic_char(input logic fmt, input logic [POS_BITS-1:0] p);
        logic [7:0] c;
        if (fmt == FMT_BGRA) begin
            case (p)
                6'd0:                      c = "B";
                6'd1:                      c = "G";
                6'd2:                      c = "R";
                6'd3:                      c = "A";
                6'd4, 6'd5, 6'd6, 6'd7:    c = "8";
                default:                   c = CHR_NONE;
            endcase
        end else begin
            case (p)
                6'd0:    c = "Y";
                6'd1:    c = "U";
                6'd2:    c = "V";
                6'd3:    c = "4";
                6'd4:    c = "M";
                6'd5:    c = "P";
                6'd6:    c = "E";
                6'd7:    c = "G";
                6'd8:    c = "2";
                default: c = CHR_NONE;
            endcase
        end
        return c;
    endfunction

    function automatic num_slot_t pos_slot(input logic [POS_BITS-1:0] p);
        num_slot_t s;
        if (p <= 6'd12) begin
            s = SLOT_WIDTH;
        end else if (p <= 6'd16) begin
            s = SLOT_HEIGHT;
        end else if (p <= 6'd20) begin
            s = SLOT_RATE_NUM;
        end else if (p <= 6'd22) begin
            s = SLOT_RATE_DEN;
        end else if (p <= 6'd29) begin
            s = SLOT_ASPECT_NUM;
        end else begin
            s = SLOT_ASPECT_DEN;
        end
        return s;
    endfunction

endpackage

// ----- src/y4m_stream_header_parser_top.sv -----
// An accepted item passes through the input register, then the result register, before its result shows on m_*.
// Throughput: one byte per cycle while m_ready drains the result register; a one-item input
// register keeps s_ready high for one more item while a result waits on m_ready.
// The frame area comes from a registered width*height product that tracks the header numbers.
// Reset: synchronous, active low aresetn; empties both registers and returns the parser
// to the first magic byte with all parsed numbers cleared.
// ----------------------------------------------------------------------------
// y4m_stream_header_parser_top
// Parses a YUV4MPEG2 / BGRA8888 stream header and frame lines byte by byte and
// passes frame payload bytes through with the last one of each frame marked.
// ----------------------------------------------------------------------------
`include "y4m_stream_header_parser_top_macros.svh"

module y4m_stream_header_parser_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  y4m_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output y4m_pkg::out_item_t  m_data
);
    import y4m_pkg::*;

    // Handshake registers
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    out_item_t result;
    logic      advance;

    // Parser state
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic                  fmt_reg, fmt_next;
    logic [DIM_BITS-1:0]   width_reg, width_next;
    logic [DIM_BITS-1:0]   height_reg, height_next;
    logic [RATIO_BITS-1:0] rate_num_reg, rate_num_next;
    logic [RATIO_BITS-1:0] rate_den_reg, rate_den_next;
    logic [7:0]            interlace_reg, interlace_next;
    logic [RATIO_BITS-1:0] aspect_num_reg, aspect_num_next;
    logic [RATIO_BITS-1:0] aspect_den_reg, aspect_den_next;
    logic [PAY_BITS-1:0]   payload_left_reg, payload_left_next;
    logic [AREA_BITS-1:0]  area_reg;

    // Decode helpers
    logic [7:0]          cur_byte;
    logic                is_digit;
    logic [3:0]          digit_val;
    logic                skip_term;
    logic [POS_BITS-1:0] eff_pos;
    logic [POS_BITS-1:0] pos_inc;
    pos_kind_t           kind;
    logic [7:0]          want;
    logic [POS_BITS-1:0] magic_len;
    num_slot_t           slot;
    logic [ACC_BITS-1:0] acc_cur;
    logic [ACC_BITS+3:0] acc_mul;
    logic [ACC_BITS-1:0] acc_lim;
    logic [ACC_BITS-1:0] acc_sat;
    logic [ACC_BITS-1:0] acc_wr;
    logic                acc_en;
    logic [PAY_BITS-1:0] frame_bytes;
    logic [PAY_BITS-1:0] payload_dec;

    // Move the held item forward when the result register is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // Track input and output register occupancy
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Decode the byte against the current header position
    always_comb begin
        cur_byte  = in_item_reg.stream_byte;
        is_digit  = (cur_byte >= CHR_ZERO) && (cur_byte <= CHR_NINE);
        digit_val = 4'(cur_byte - CHR_ZERO);
        // a number ended by a byte that belongs to the next literal
        skip_term = (pos_kind(pos_reg) == K_MORE) && !is_digit && (pos_char(pos_reg) == CHR_NONE);
        eff_pos   = skip_term ? POS_BITS'(pos_reg + 6'd1) : pos_reg;
        pos_inc   = POS_BITS'(eff_pos + 6'd1);
        kind      = pos_kind(eff_pos);
        want      = pos_char(eff_pos);
        magic_len = (fmt_reg == FMT_BGRA) ? MAGIC_LEN_BGRA : MAGIC_LEN_YUV;
        slot      = pos_slot(pos_reg);
    end

    // Shared decimal accumulator: value*10 + digit, saturating
    always_comb begin
        case (slot)
            SLOT_WIDTH:      acc_cur = ACC_BITS'(width_reg);
            SLOT_HEIGHT:     acc_cur = ACC_BITS'(height_reg);
            SLOT_RATE_NUM:   acc_cur = ACC_BITS'(rate_num_reg);
            SLOT_RATE_DEN:   acc_cur = ACC_BITS'(rate_den_reg);
            SLOT_ASPECT_NUM: acc_cur = ACC_BITS'(aspect_num_reg);
            SLOT_ASPECT_DEN: acc_cur = ACC_BITS'(aspect_den_reg);
            default:         acc_cur = '0;
        endcase
        acc_lim = ((slot == SLOT_WIDTH) || (slot == SLOT_HEIGHT)) ? DIM_MAX : RATIO_MAX;
        acc_mul = ((ACC_BITS+4)'(acc_cur) << 3) + ((ACC_BITS+4)'(acc_cur) << 1)
                + (ACC_BITS+4)'(digit_val);
        acc_sat = (acc_mul > (ACC_BITS+4)'(acc_lim)) ? acc_lim : acc_mul[ACC_BITS-1:0];
    end

    // Payload length from the registered area
    always_comb begin
        if (fmt_reg == FMT_BGRA) begin
            frame_bytes = PAY_BITS'(area_reg) << 2;
        end else begin
            frame_bytes = (PAY_BITS'(area_reg) + (PAY_BITS'(area_reg) << 1)) >> 1;
        end
        payload_dec = payload_left_reg - PAY_BITS'(1);
    end

    // Parser step and result assembly
    always_comb begin
        pos_next          = pos_reg;
        fmt_next          = fmt_reg;
        interlace_next    = interlace_reg;
        payload_left_next = payload_left_reg;
        acc_wr            = acc_sat;
        acc_en            = 1'b0;
        result            = '0;
        result.event_kind = EV_CONSUMED;

        case (kind)
            K_MAGIC: begin
                if (eff_pos == POS_START) begin
                    if (cur_byte == magic_char(FMT_YUV420, POS_START)) begin
                        fmt_next = FMT_YUV420;
                        pos_next = pos_inc;
                    end else if (cur_byte == magic_char(FMT_BGRA, POS_START)) begin
                        fmt_next = FMT_BGRA;
                        pos_next = pos_inc;
                    end else begin
                        pos_next          = POS_ERROR;
                        result.event_kind = EV_ERROR;
                    end
                end else if ((eff_pos >= magic_len)
                             || (cur_byte != magic_char(fmt_reg, eff_pos))) begin
                    pos_next          = POS_ERROR;
                    result.event_kind = EV_ERROR;
                end else begin
                    pos_next = (pos_inc == magic_len) ? POS_AFTER_MAGIC : pos_inc;
                end
            end
            K_LIT: begin
                if (cur_byte != want) begin
                    pos_next          = POS_ERROR;
                    result.event_kind = EV_ERROR;
                end else begin
                    pos_next = pos_inc;
                end
            end
            K_FIRST: begin
                if (!is_digit) begin
                    pos_next          = POS_ERROR;
                    result.event_kind = EV_ERROR;
                end else begin
                    acc_wr   = ACC_BITS'(digit_val);
                    acc_en   = 1'b1;
                    pos_next = pos_inc;
                end
            end
            K_MORE: begin
                if (is_digit) begin
                    acc_en = 1'b1;
                end else if (cur_byte != want) begin
                    pos_next          = POS_ERROR;
                    result.event_kind = EV_ERROR;
                end else if (eff_pos == POS_HEADER_END) begin
                    pos_next                  = POS_FRAME;
                    result.event_kind         = EV_STREAM;
                    result.frame_width        = 16'(width_reg);
                    result.frame_height       = 16'(height_reg);
                    result.pixel_format       = fmt_reg;
                    result.rate_numerator     = 32'(rate_num_reg);
                    result.rate_denominator   = 32'(rate_den_reg);
                    result.interlace_code     = interlace_reg;
                    result.aspect_numerator   = 32'(aspect_num_reg);
                    result.aspect_denominator = 32'(aspect_den_reg);
                end else begin
                    pos_next = pos_inc;
                end
            end
            K_CHAR: begin
                interlace_next = cur_byte;
                pos_next       = pos_inc;
            end
            K_FRAME: begin
                if (cur_byte != want) begin
                    pos_next          = POS_ERROR;
                    result.event_kind = EV_ERROR;
                end else if (eff_pos == POS_FRAME_END) begin
                    payload_left_next = frame_bytes;
                    pos_next          = (frame_bytes != '0) ? POS_PAYLOAD : POS_FRAME;
                    result.event_kind = EV_FRAME;
                end else begin
                    pos_next = pos_inc;
                end
            end
            K_PAYLOAD: begin
                payload_left_next   = payload_dec;
                result.event_kind   = EV_PAYLOAD;
                result.payload_byte = cur_byte;
                if (payload_dec == '0) begin
                    result.last_of_frame = 1'b1;
                    pos_next             = POS_FRAME;
                end
            end
            default: begin
                pos_next          = POS_ERROR;
                result.event_kind = EV_ERROR;
            end
        endcase

        // Write back the accumulated number
        width_next      = width_reg;
        height_next     = height_reg;
        rate_num_next   = rate_num_reg;
        rate_den_next   = rate_den_reg;
        aspect_num_next = aspect_num_reg;
        aspect_den_next = aspect_den_reg;
        if (acc_en) begin
            case (slot)
                SLOT_WIDTH:      width_next      = DIM_BITS'(acc_wr);
                SLOT_HEIGHT:     height_next     = DIM_BITS'(acc_wr);
                SLOT_RATE_NUM:   rate_num_next   = RATIO_BITS'(acc_wr);
                SLOT_RATE_DEN:   rate_den_next   = RATIO_BITS'(acc_wr);
                SLOT_ASPECT_NUM: aspect_num_next = RATIO_BITS'(acc_wr);
                SLOT_ASPECT_DEN: aspect_den_next = RATIO_BITS'(acc_wr);
                default:         width_next      = width_reg;
            endcase
        end

        // Restart drops back to the stream start
        if (in_item_reg.restart) begin
            pos_next          = POS_START;
            fmt_next          = FMT_YUV420;
            width_next        = '0;
            height_next       = '0;
            rate_num_next     = '0;
            rate_den_next     = '0;
            interlace_next    = '0;
            aspect_num_next   = '0;
            aspect_den_next   = '0;
            payload_left_next = '0;
            result            = '0;
            result.event_kind = EV_CONSUMED;
        end
    end

    // Control and parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pos_reg          <= POS_START;
            fmt_reg          <= FMT_YUV420;
            width_reg        <= '0;
            height_reg       <= '0;
            rate_num_reg     <= '0;
            rate_den_reg     <= '0;
            interlace_reg    <= '0;
            aspect_num_reg   <= '0;
            aspect_den_reg   <= '0;
            payload_left_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                pos_reg          <= pos_next;
                fmt_reg          <= fmt_next;
                width_reg        <= width_next;
                height_reg       <= height_next;
                rate_num_reg     <= rate_num_next;
                rate_den_reg     <= rate_den_next;
                interlace_reg    <= interlace_next;
                aspect_num_reg   <= aspect_num_next;
                aspect_den_reg   <= aspect_den_next;
                payload_left_reg <= payload_left_next;
            end
        end
    end

    // Payload registers and the frame area product
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= result;
        end
        area_reg <= AREA_BITS'(width_reg) * AREA_BITS'(height_reg);
    end

    // Checks
    `Y4M_ASSERT_NXT(a_error_sticky,
        advance && (pos_reg == POS_ERROR) && !in_item_reg.restart,
        (pos_reg == POS_ERROR) && (out_item_reg.event_kind == EV_ERROR),
        "error state left without restart")
    `Y4M_ASSERT_IMP(a_payload_nonzero,
        pos_reg == POS_PAYLOAD,
        payload_left_reg != '0,
        "payload state with no bytes left")
    `Y4M_ASSERT_NXT(a_last_marked,
        advance && (pos_reg == POS_PAYLOAD) && !in_item_reg.restart
            && (payload_left_reg == PAY_BITS'(1)),
        m_valid && m_data.last_of_frame && (pos_reg == POS_FRAME),
        "final payload byte not marked")
    `Y4M_ASSERT_NXT(a_input_held,
        in_valid_reg && !advance,
        in_valid_reg && $stable(in_item_reg),
        "held input item lost or changed")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Y4M stream header parser testbench
// Feeds byte streams (clean headers and frames, corrupted streams, noise and
// restarts) through the valid/ready input and checks every result item
// against a behavioral parser kept alongside, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import y4m_pkg::*;

    localparam int    TOTAL_ITEMS     = 900;
    localparam int    PAYLOAD_CAP     = 200;
    localparam int    DRAIN_SLACK     = 10;
    localparam string HEADER_TEMPLATE = " W# H# F#:# I? A#:#\n";
    localparam string FRAME_LINE      = "FRAME\n";
    localparam logic [63:0] DIM_LIMIT   = (64'd1 << DIM_BITS) - 64'd1;
    localparam logic [63:0] RATIO_LIMIT = (64'd1 << RATIO_BITS) - 64'd1;

    typedef enum logic [2:0] {
        MODE_MAGIC,
        MODE_HEADER,
        MODE_FRAME_LINE,
        MODE_PAYLOAD,
        MODE_FAILED
    } parse_mode_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;

    // Parser state as predicted from the accepted bytes
    parse_mode_t cur_mode;
    logic        cur_fmt;
    int          cur_idx;
    logic        in_number;
    int          number_sel;
    logic [63:0] numbers [6];
    logic [7:0]  interlace_char;
    logic [63:0] payload_remaining;

    out_item_t expected_events [$];
    int        fail_count      = 0;
    int        counted_items   = 0;
    int        mutate_pct      = 0;
    bit        sender_idles    = 1'b0;
    bit        receiver_idles  = 1'b0;
    int        receiver_hold   = 0;

    y4m_stream_header_parser_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Drop the predicted parser back to the first magic byte
    function automatic void clear_parser();
        cur_mode          = MODE_MAGIC;
        cur_fmt           = FMT_YUV420;
        cur_idx           = 0;
        in_number         = 1'b0;
        number_sel        = 0;
        interlace_char    = 8'h00;
        payload_remaining = 64'd0;
        for (int i = 0; i < 6; i++) numbers[i] = 64'd0;
    endfunction

    // Advance the predicted parser by one item and return the result it causes
    function automatic out_item_t parse_stream_byte(input in_item_t item);
        out_item_t   ev;
        logic [7:0]  b;
        logic [7:0]  want;
        logic        is_digit;
        logic [63:0] acc;
        logic [63:0] lim;
        logic [63:0] area;
        string       magic;
        ev = '0;
        ev.event_kind = EV_CONSUMED;
        b = item.stream_byte;
        if (item.restart) begin
            clear_parser();
            return ev;
        end
        is_digit = (b >= "0") && (b <= "9");
        case (cur_mode)
            MODE_MAGIC: begin
                if (cur_idx == 0) begin
                    if (b == "Y") cur_fmt = FMT_YUV420;
                    else if (b == "B") cur_fmt = FMT_BGRA;
                    else cur_mode = MODE_FAILED;
                end
                if (cur_fmt == FMT_BGRA) magic = "BGRA8888";
                else magic = "YUV4MPEG2";
                if (cur_mode != MODE_FAILED) begin
                    want = magic[cur_idx];
                    if (b != want) begin
                        cur_mode = MODE_FAILED;
                    end else begin
                        cur_idx++;
                        if (cur_idx == magic.len()) begin
                            cur_mode = MODE_HEADER;
                            cur_idx  = 0;
                        end
                    end
                end
            end
            MODE_HEADER: begin
                if (in_number && is_digit) begin
                    // accumulate, saturating at the field's limit
                    lim = (number_sel < 2) ? DIM_LIMIT : RATIO_LIMIT;
                    acc = numbers[number_sel] * 64'd10 + 64'(b - "0");
                    numbers[number_sel] = (acc > lim) ? lim : acc;
                end else begin
                    // a non-digit ends the number and is matched against what follows
                    if (in_number) begin
                        in_number = 1'b0;
                        number_sel++;
                        cur_idx++;
                    end
                    want = HEADER_TEMPLATE[cur_idx];
                    if (want == "#") begin
                        if (!is_digit) begin
                            cur_mode = MODE_FAILED;
                        end else begin
                            numbers[number_sel] = 64'(b - "0");
                            in_number = 1'b1;
                        end
                    end else if (want == "?") begin
                        interlace_char = b;
                        cur_idx++;
                    end else if (b != want) begin
                        cur_mode = MODE_FAILED;
                    end else begin
                        cur_idx++;
                        if (cur_idx == HEADER_TEMPLATE.len()) begin
                            ev.event_kind         = EV_STREAM;
                            ev.frame_width        = numbers[0][15:0];
                            ev.frame_height       = numbers[1][15:0];
                            ev.pixel_format       = cur_fmt;
                            ev.rate_numerator     = numbers[2][31:0];
                            ev.rate_denominator   = numbers[3][31:0];
                            ev.interlace_code     = interlace_char;
                            ev.aspect_numerator   = numbers[4][31:0];
                            ev.aspect_denominator = numbers[5][31:0];
                            cur_mode = MODE_FRAME_LINE;
                            cur_idx  = 0;
                        end
                    end
                end
            end
            MODE_FRAME_LINE: begin
                want = FRAME_LINE[cur_idx];
                if (b != want) begin
                    cur_mode = MODE_FAILED;
                end else begin
                    cur_idx++;
                    if (cur_idx == FRAME_LINE.len()) begin
                        area = numbers[0] * numbers[1];
                        payload_remaining = (cur_fmt == FMT_BGRA) ? area * 64'd4
                                                                  : (area * 64'd6) / 64'd4;
                        ev.event_kind = EV_FRAME;
                        cur_idx = 0;
                        if (payload_remaining != 64'd0) cur_mode = MODE_PAYLOAD;
                    end
                end
            end
            MODE_PAYLOAD: begin
                payload_remaining--;
                ev.event_kind   = EV_PAYLOAD;
                ev.payload_byte = b;
                if (payload_remaining == 64'd0) begin
                    ev.last_of_frame = 1'b1;
                    cur_mode = MODE_FRAME_LINE;
                    cur_idx  = 0;
                end
            end
            default: ;
        endcase
        if (cur_mode == MODE_FAILED) begin
            ev = '0;
            ev.event_kind = EV_ERROR;
        end
        return ev;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int idle_length(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 75) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Offer one item, hold it until accepted, then record its expected result
    task automatic send_item(input logic [7:0] b, input logic rst);
        in_item_t item;
        int       gap;
        item.stream_byte = b;
        item.restart     = rst;
        gap = idle_length(sender_idles);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        counted_items++;
        expected_events.push_back(parse_stream_byte(item));
        @(negedge aclk);
    endtask

    task automatic send_restart();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Send text, replacing bytes at random while corruption is enabled
    task automatic send_text(input string txt);
        logic [7:0] b;
        for (int i = 0; i < txt.len(); i++) begin
            b = txt[i];
            if (mutate_pct > 0 && $urandom_range(0, 99) < mutate_pct)
                b = 8'($urandom_range(0, 255));
            send_item(b, 1'b0);
        end
    endtask

    task automatic send_stream_header(input logic fmt, input string w_txt, input string h_txt,
                                      input string fn_txt, input string fd_txt,
                                      input logic [7:0] ilace, input string an_txt,
                                      input string ad_txt);
        string magic;
        if (fmt == FMT_BGRA) magic = "BGRA8888";
        else magic = "YUV4MPEG2";
        send_text({magic, " W", w_txt, " H", h_txt, " F", fn_txt, ":", fd_txt, " I"});
        send_item(ilace, 1'b0);
        send_text({" A", an_txt, ":", ad_txt, "\n"});
    endtask

    // Fill the rest of the current frame with random bytes, bounded in length
    task automatic finish_frame();
        int sent;
        sent = 0;
        while (cur_mode == MODE_PAYLOAD && sent < PAYLOAD_CAP) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
            sent++;
        end
    endtask

    task automatic send_frame();
        send_text(FRAME_LINE);
        finish_frame();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic string digit_string(input int count);
        string txt;
        txt = "";
        repeat (count) txt = $sformatf("%s%c", txt, 8'($urandom_range(48, 57)));
        return txt;
    endfunction

    function automatic string dim_text();
        string txt;
        txt = $sformatf("%0d", $urandom_range(0, 6));
        if ($urandom_range(0, 4) == 0) txt = {"0", txt};
        return txt;
    endfunction

    function automatic string ratio_text();
        if ($urandom_range(0, 9) < 7) return digit_string($urandom_range(1, 3));
        return digit_string($urandom_range(8, 12));
    endfunction

    // Check each result item against the oldest expectation
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch("result with nothing pending", 64'(m_data.event_kind), 64'd0);
            end else begin
                want = expected_events.pop_front();
                if (m_data.event_kind !== want.event_kind)
                    report_mismatch("event_kind", 64'(m_data.event_kind),
                                    64'(want.event_kind));
                if (m_data.frame_width !== want.frame_width)
                    report_mismatch("frame_width", 64'(m_data.frame_width),
                                    64'(want.frame_width));
                if (m_data.frame_height !== want.frame_height)
                    report_mismatch("frame_height", 64'(m_data.frame_height),
                                    64'(want.frame_height));
                if (m_data.pixel_format !== want.pixel_format)
                    report_mismatch("pixel_format", 64'(m_data.pixel_format),
                                    64'(want.pixel_format));
                if (m_data.rate_numerator !== want.rate_numerator)
                    report_mismatch("rate_numerator", 64'(m_data.rate_numerator),
                                    64'(want.rate_numerator));
                if (m_data.rate_denominator !== want.rate_denominator)
                    report_mismatch("rate_denominator", 64'(m_data.rate_denominator),
                                    64'(want.rate_denominator));
                if (m_data.interlace_code !== want.interlace_code)
                    report_mismatch("interlace_code", 64'(m_data.interlace_code),
                                    64'(want.interlace_code));
                if (m_data.aspect_numerator !== want.aspect_numerator)
                    report_mismatch("aspect_numerator", 64'(m_data.aspect_numerator),
                                    64'(want.aspect_numerator));
                if (m_data.aspect_denominator !== want.aspect_denominator)
                    report_mismatch("aspect_denominator", 64'(m_data.aspect_denominator),
                                    64'(want.aspect_denominator));
                if (m_data.payload_byte !== want.payload_byte)
                    report_mismatch("payload_byte", 64'(m_data.payload_byte),
                                    64'(want.payload_byte));
                if (m_data.last_of_frame !== want.last_of_frame)
                    report_mismatch("last_of_frame", 64'(m_data.last_of_frame),
                                    64'(want.last_of_frame));
            end
        end
    end

    // Result side: random stalls, plus long hold-offs on request
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (receiver_hold != 0) begin
                hold_left     = receiver_hold;
                receiver_hold = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                stall_left = idle_length(receiver_idles);
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // Clean planar stream, including a one-byte frame and truncated sizes
    task automatic test_yuv_stream();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        send_item(8'hFF, 1'b1);
        send_stream_header(FMT_YUV420, "4", "2", "30000", "1001", "p", "1", "1");
        send_text(FRAME_LINE);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        finish_frame();
        send_frame();
        send_restart();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        send_stream_header(FMT_YUV420, "1", "1", "25", "1", "t", "0", "1");
        send_frame();
        send_restart();
        send_stream_header(FMT_YUV420, "3", "1", "24", "1", "b", "16", "15");
        send_frame();
        send_frame();
    endtask

    // Packed stream with a zero frame rate (0:0), a null interlace byte and aspect saturation
    task automatic test_bgra_stream();
        send_restart();
        send_stream_header(FMT_BGRA, "2", "1", "0", "0", 8'h00, "4294967295", "4294967296");
        send_frame();
        send_frame();
    endtask

    // Saturating sizes paired with a zero size give back-to-back empty frames
    task automatic test_saturation_and_empty_frames();
        send_restart();
        send_stream_header(FMT_YUV420, "99999", "0", "99999999999", "7", 8'hFF, "0012", "00");
        send_text({FRAME_LINE, FRAME_LINE});
        send_restart();
        send_stream_header(FMT_BGRA, "0", "65535", "65536", "1", "m", "1", "99999999999999");
        send_text({FRAME_LINE, FRAME_LINE});
        send_restart();
        send_stream_header(FMT_YUV420, "65536", "000", "1", "1", "p", "1", "1");
        send_frame();
    endtask

    // Mismatches anywhere in the header or frame line, sticky until restart
    task automatic test_header_errors();
        send_restart();
        send_text("XYUV");
        send_restart();
        send_text("YUV4MPEG2 W H1");
        send_restart();
        send_text("BGRA88888");
        send_restart();
        send_text("YUV4MPEG2 W3x");
        send_restart();
        send_text("YUV4MPEG2 W1 H1 F1:1 I? A1:1 ");
        send_restart();
        send_stream_header(FMT_YUV420, "1", "1", "1", "1", "?", "1", "1");
        send_text("FRAMX\n");
        send_restart();
        send_text("YUV4MPE");
        send_restart();
        send_text("YGRA");
        send_restart();
        send_stream_header(FMT_YUV420, "1", "2", "1", "1", "p", "1", "1");
        send_frame();
        send_text("YUV4MPEG2");
    endtask

    // Hold the result side off while bytes keep coming so the input stalls
    task automatic test_output_stall();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        send_restart();
        receiver_hold = 60;
        send_stream_header(FMT_BGRA, "2", "2", "25", "1", "p", "1", "1");
        send_frame();
        wait_drained();
    endtask

    // Pause the sender mid-header until every result is back, then carry on
    task automatic test_pause_until_drained();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        send_restart();
        send_text("YUV4MPEG2 W5 H");
        wait_drained();
        send_text("3 F50:1 Ip A1:1\n");
        wait_drained();
        send_frame();
        wait_drained();
    endtask

    task automatic send_random_stream();
        string w_txt;
        string h_txt;
        logic  fmt;
        bit    big_dim;
        fmt     = 1'($urandom_range(0, 1));
        big_dim = ($urandom_range(0, 19) == 0);
        if (big_dim) begin
            // one saturated size, the other zero, so frames stay empty
            w_txt = digit_string($urandom_range(6, 8));
            w_txt = {"9", w_txt};
            h_txt = ($urandom_range(0, 1) == 0) ? "0" : "00";
            if ($urandom_range(0, 1) == 0) begin
                h_txt = w_txt;
                w_txt = "0";
            end
        end else begin
            w_txt = dim_text();
            h_txt = dim_text();
        end
        if ($urandom_range(0, 9) != 0) send_restart();
        mutate_pct = (!big_dim && $urandom_range(0, 4) == 0) ? 2 : 0;
        send_stream_header(fmt, w_txt, h_txt, ratio_text(), ratio_text(),
                           8'($urandom_range(0, 255)), ratio_text(), ratio_text());
        repeat ($urandom_range(0, 4)) send_frame();
        mutate_pct = 0;
    endtask

    task automatic send_noise();
        string prefix;
        int    r;
        r = $urandom_range(0, 2);
        if (r == 0) begin
            send_restart();
            repeat ($urandom_range(5, 25)) send_item(8'($urandom_range(0, 255)), 1'b0);
        end else if (r == 1) begin
            // a header cut off at a random point, then garbage
            prefix = ($urandom_range(0, 1) == 0) ? "YUV4MPEG2 W12 H34 F25:1 Ip A1:1\n"
                                                 : "BGRA8888 W3 H2 F60:1 I? A10:11\n";
            send_restart();
            send_text(prefix.substr(0, $urandom_range(0, prefix.len() - 1)));
            repeat ($urandom_range(1, 10)) send_item(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            repeat ($urandom_range(5, 25))
                send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
        end
    endtask

    // Mostly well-formed streams with random content, some corrupted, some noise
    task automatic test_random_streams();
        while (counted_items < TOTAL_ITEMS) begin
            sender_idles   = ($urandom_range(0, 9) != 0);
            receiver_idles = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 99) < 85) send_random_stream();
            else send_noise();
            if ($urandom_range(0, 29) == 0) wait_drained();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        clear_parser();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        test_yuv_stream();
        test_bgra_stream();
        test_saturation_and_empty_frames();
        test_header_errors();
        test_output_stall();
        test_pause_until_drained();
        test_random_streams();
        wait_drained();
        repeat (DRAIN_SLACK) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #6_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
